// ===== hdl/smst_pkg.sv =====
// Shared types, register codes and constants of the spectrum mode slew tracker.
package smst_pkg;

  localparam int MAX_BINS_DEF = 256;
  localparam int MIN_BINS     = 6;
  localparam int REG_W        = 16;
  localparam int BIN_REG_W    = 9;

  localparam logic [15:0] TARGET_BASE = 16'd8192;
  localparam logic [17:0] TARGET_TOP  = 18'd61440;
  localparam logic [11:0] LW_LOW      = 12'd983;
  localparam logic [11:0] LW_SPAN     = 12'd2949;
  localparam logic [16:0] NORM_ONE    = 17'd65536;

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_BIN_COUNT     = 3'd0,
    REG_RMS_DECAY     = 3'd1,
    REG_FLUX_DECAY    = 3'd2,
    REG_MODE_STEP_MIN = 3'd3,
    REG_MODE_STEP_MAX = 3'd4,
    REG_TURN_STEP_MIN = 3'd5,
    REG_TURN_STEP_MAX = 3'd6
  } reg_idx_e;

  localparam logic [8:0]  BIN_COUNT_RST     = 9'd256;
  localparam logic [15:0] RMS_DECAY_RST     = 16'd65309;
  localparam logic [15:0] FLUX_DECAY_RST    = 16'd64975;
  localparam logic [15:0] MODE_STEP_MIN_RST = 16'd34;
  localparam logic [15:0] MODE_STEP_MAX_RST = 16'd273;
  localparam logic [15:0] TURN_STEP_MIN_RST = 16'd52;
  localparam logic [15:0] TURN_STEP_MAX_RST = 16'd348;

  typedef struct packed {
    logic [15:0] rms_decay;
    logic [15:0] flux_decay;
    logic [15:0] mode_step_min;
    logic [15:0] mode_step_max;
    logic [15:0] turn_step_min;
    logic [15:0] turn_step_max;
  } cfg_t;

  typedef struct packed {
    logic [11:0] line_width;
    logic [15:0] turn;
    logic [15:0] mode_n;
    logic [15:0] mode_m;
  } res_t;

endpackage

// ===== hdl/smst_prev_mem.sv =====
// Previous-frame magnitude memory with a fill count standing in for a cleared store.
module smst_prev_mem import smst_pkg::*; #(
  parameter int DEPTH = MAX_BINS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     clr_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [15:0]              rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [15:0]              wr_data_i
);
  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);

  logic [15:0]   mem_q [DEPTH];
  logic [15:0]   rd_q;
  logic          rd_valid_q;
  logic [FW-1:0] fill_q;

  // Write port and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // Track how many entries have been written since the last clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (rd_en_i) begin
        rd_valid_q <= (FW'(rd_addr_i) < fill_q);
      end
      if (clr_i) begin
        fill_q <= '0;
      end else if (wr_en_i && (FW'(wr_addr_i) == fill_q)) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  // An entry beyond the fill count reads as zero
  assign rd_data_o = rd_valid_q ? rd_q : 16'd0;

endmodule

// ===== hdl/smst_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module smst_div #(
  parameter int NW = 32,
  parameter int DW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);
  localparam int CNTW = $clog2(NW + 1);

  logic [CNTW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [DW-1:0]   rem_q;
  logic [DW-1:0]   den_q;
  logic [NW-1:0]   quo_q;
  logic [DW:0]     trial;
  logic            qbit;
  logic [DW-1:0]   rem_d;

  // Shift in the next numerator bit and try the subtraction
  always_comb begin
    trial = {rem_q, quo_q[NW-1]};
    qbit  = (trial >= {1'b0, den_q});
    rem_d = qbit ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(NW);
        rem_q  <= '0;
        den_q  <= den_i;
        quo_q  <= num_i;
      end else if (busy_q) begin
        rem_q <= rem_d;
        quo_q <= {quo_q[NW-2:0], qbit};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== hdl/smst_isqrt.sv =====
// Iterative integer square root of a 32-bit value, two radicand bits per cycle.
module smst_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] val_i,
  output logic        done_o,
  output logic [15:0] root_o
);
  logic [31:0] v_q;
  logic [31:0] r_q;
  logic [31:0] bit_q;
  logic        busy_q;
  logic        done_q;
  logic [31:0] trial;

  assign trial = r_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        v_q    <= val_i;
        r_q    <= '0;
        bit_q  <= 32'h4000_0000;
      end else if (busy_q) begin
        // Keep the bit where the trial fits, then advance two places
        if (v_q >= trial) begin
          v_q <= v_q - trial;
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
        if (bit_q == 32'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[15:0];

endmodule

// ===== hdl/smst_frame_calc.sv =====
// End-of-frame sequencer: RMS, decaying peaks, norms, centroids and output slewing.
module smst_frame_calc import smst_pkg::*; #(
  parameter int MAX_BINS = MAX_BINS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [$clog2(MAX_BINS+1)-1:0]         count_i,
  input  logic [$clog2(MAX_BINS+1)-1:0]         band_i,
  input  logic [32+$clog2(MAX_BINS+1)-1:0]      sq_i,
  input  logic [16+$clog2(MAX_BINS+1)-1:0]      flux_i,
  input  logic [2:0][16+$clog2(MAX_BINS)+$clog2(MAX_BINS+1)-1:0] wsum_i,
  input  logic [2:0][16+$clog2(MAX_BINS+1)-1:0] tot_i,
  input  cfg_t                                  cfg_i,
  input  logic                                  out_free_i,
  output logic                                  busy_o,
  output logic                                  done_o,
  output res_t                                  res_o
);
  localparam int AW   = $clog2(MAX_BINS);
  localparam int CW   = $clog2(MAX_BINS + 1);
  localparam int SQ_W = 32 + CW;
  localparam int FX_W = 16 + CW;
  localparam int TW   = 16 + CW;
  localparam int WW   = 16 + AW + CW;
  localparam int PW   = TW + AW;
  localparam int NW   = WW + 18;
  localparam int DDW  = PW + 1;

  typedef enum logic [3:0] {
    C_IDLE, C_MEAN, C_ROOT, C_PEAK, C_NF_GO, C_NF_WT, C_NR_GO, C_NR_WT,
    C_STEP, C_CPREP, C_CGO, C_CWT, C_OUT
  } calc_state_e;

  calc_state_e     st_q;
  logic [1:0]      b_q;
  logic [15:0]     rms_q;
  logic [15:0]     peak_rms_q;
  logic [FX_W-1:0] peak_flux_q;
  logic [16:0]     nflux_q;
  logic [16:0]     nrms_q;
  logic [15:0]     mstep_q;
  logic [15:0]     tstep_q;
  logic [11:0]     lw_q;
  logic [PW-1:0]   den_q;
  logic [2:0][16:0] cent_q;
  logic [15:0]     cur_m_q;
  logic [15:0]     cur_n_q;
  logic [15:0]     cur_t_q;
  logic            done_q;

  logic            div_start;
  logic [NW-1:0]   div_num;
  logic [DDW-1:0]  div_den;
  logic            div_done;
  logic [NW-1:0]   div_quo;
  logic            rt_start;
  logic            rt_done;
  logic [15:0]     rt_root;

  logic [31:0]        dec_r_prod;
  logic [FX_W+15:0]   dec_f_prod;
  logic [15:0]        peak_rms_d;
  logic [FX_W-1:0]    peak_flux_d;
  logic [AW-1:0]      wm1;
  logic [WW+3:0]      w13;
  logic [NW-1:0]      cnum;
  logic [16:0]        quo_norm;
  logic [28:0]        lw_prod;
  logic [15:0]        tgt_m;
  logic [15:0]        tgt_n;
  logic [15:0]        new_m;
  logic [15:0]        new_n;
  logic [15:0]        new_t;

  // Rounded signed interpolation between two step limits
  function automatic logic [15:0] lerp(input logic [15:0] lo, input logic [15:0] hi,
                                       input logic [16:0] n);
    logic [15:0] diff;
    logic [32:0] prod;
    logic [32:0] rnd;
    begin
      diff = (hi >= lo) ? (hi - lo) : (lo - hi);
      prod = diff * n;
      rnd  = (prod + 33'd32768) >> 16;
      lerp = (hi >= lo) ? (lo + rnd[15:0]) : (lo - rnd[15:0]);
    end
  endfunction

  // Clamp a signed distance to plus or minus the step
  function automatic logic [15:0] clamp(input logic signed [17:0] d,
                                        input logic [15:0] step);
    logic signed [17:0] s;
    logic signed [17:0] r;
    begin
      s = $signed({2'b00, step});
      r = d;
      if (r > s) r = s;
      if (r < -s) r = -s;
      clamp = r[15:0];
    end
  endfunction

  function automatic logic [15:0] mode_tgt(input logic [16:0] c);
    logic [17:0] t;
    begin
      t = {2'b00, TARGET_BASE} + {1'b0, c};
      if (t > TARGET_TOP) t = TARGET_TOP;
      mode_tgt = t[15:0];
    end
  endfunction

  // Peak decay products and new peaks
  always_comb begin
    dec_r_prod  = peak_rms_q * cfg_i.rms_decay;
    dec_f_prod  = peak_flux_q * cfg_i.flux_decay;
    peak_rms_d  = (rms_q > dec_r_prod[31:16]) ? rms_q : dec_r_prod[31:16];
    peak_flux_d = (flux_i > dec_f_prod[FX_W+15:16]) ? flux_i : dec_f_prod[FX_W+15:16];
  end

  // Band width less one and centroid numerator
  always_comb begin
    if (b_q == 2'd2) begin
      wm1 = AW'(count_i - (band_i << 1) - 1'b1);
    end else begin
      wm1 = AW'(band_i - 1'b1);
    end
    w13 = ({4'b0, wsum_i[b_q]} << 3) + ({4'b0, wsum_i[b_q]} << 2) + {4'b0, wsum_i[b_q]};
    if (b_q == 2'd2) begin
      cnum = {1'b0, wsum_i[b_q], 17'd0} + NW'(den_q);
    end else begin
      cnum = NW'({w13, 13'd0}) + NW'(den_q);
    end
    quo_norm = (div_quo > NW'(NORM_ONE)) ? NORM_ONE : div_quo[16:0];
    lw_prod  = LW_SPAN * nrms_q;
  end

  // Targets and slewed outputs
  always_comb begin
    tgt_m = mode_tgt(cent_q[0]);
    tgt_n = mode_tgt(cent_q[1]);
    new_m = cur_m_q + clamp($signed({2'b00, tgt_m}) - $signed({2'b00, cur_m_q}), mstep_q);
    new_n = cur_n_q + clamp($signed({2'b00, tgt_n}) - $signed({2'b00, cur_n_q}), mstep_q);
    new_t = cur_t_q + clamp(18'(signed'(cent_q[2][15:0] - cur_t_q)), tstep_q);
  end

  // Launch the shared units
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    rt_start  = 1'b0;
    case (st_q)
      C_IDLE: begin
        div_start = start_i;
        div_num   = NW'(sq_i);
        div_den   = DDW'(count_i);
      end
      C_MEAN: begin
        rt_start = div_done;
      end
      C_NF_GO: begin
        div_start = (peak_flux_q != '0);
        div_num   = NW'({flux_i, 16'd0});
        div_den   = DDW'(peak_flux_q);
      end
      C_NR_GO: begin
        div_start = (peak_rms_q != '0);
        div_num   = NW'({rms_q, 16'd0});
        div_den   = DDW'(peak_rms_q);
      end
      C_CGO: begin
        div_start = (tot_i[b_q] != '0);
        div_num   = cnum;
        div_den   = {den_q, 1'b0};
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= C_IDLE;
      done_q      <= 1'b0;
      b_q         <= '0;
      peak_rms_q  <= '0;
      peak_flux_q <= '0;
      cur_m_q     <= '0;
      cur_n_q     <= '0;
      cur_t_q     <= '0;
    end else begin
      done_q <= 1'b0;
      case (st_q)
        C_IDLE: begin
          if (start_i) st_q <= C_MEAN;
        end
        C_MEAN: begin
          if (div_done) st_q <= C_ROOT;
        end
        C_ROOT: begin
          if (rt_done) begin
            rms_q <= rt_root;
            st_q  <= C_PEAK;
          end
        end
        C_PEAK: begin
          peak_rms_q  <= peak_rms_d;
          peak_flux_q <= peak_flux_d;
          st_q        <= C_NF_GO;
        end
        C_NF_GO: begin
          if (peak_flux_q == '0) begin
            nflux_q <= '0;
            st_q    <= C_NR_GO;
          end else begin
            st_q <= C_NF_WT;
          end
        end
        C_NF_WT: begin
          if (div_done) begin
            nflux_q <= quo_norm;
            st_q    <= C_NR_GO;
          end
        end
        C_NR_GO: begin
          if (peak_rms_q == '0) begin
            nrms_q <= '0;
            st_q   <= C_STEP;
          end else begin
            st_q <= C_NR_WT;
          end
        end
        C_NR_WT: begin
          if (div_done) begin
            nrms_q <= quo_norm;
            st_q   <= C_STEP;
          end
        end
        C_STEP: begin
          mstep_q <= lerp(cfg_i.mode_step_min, cfg_i.mode_step_max, nflux_q);
          tstep_q <= lerp(cfg_i.turn_step_min, cfg_i.turn_step_max, nflux_q);
          lw_q    <= LW_LOW + 12'((lw_prod + 29'd32768) >> 16);
          b_q     <= '0;
          st_q    <= C_CPREP;
        end
        C_CPREP: begin
          den_q <= tot_i[b_q] * wm1;
          st_q  <= C_CGO;
        end
        C_CGO: begin
          if (tot_i[b_q] == '0) begin
            cent_q[b_q] <= '0;
            b_q         <= b_q + 1'b1;
            st_q        <= (b_q == 2'd2) ? C_OUT : C_CPREP;
          end else begin
            st_q <= C_CWT;
          end
        end
        C_CWT: begin
          if (div_done) begin
            cent_q[b_q] <= div_quo[16:0];
            b_q         <= b_q + 1'b1;
            st_q        <= (b_q == 2'd2) ? C_OUT : C_CPREP;
          end
        end
        C_OUT: begin
          if (out_free_i) begin
            cur_m_q <= new_m;
            cur_n_q <= new_n;
            cur_t_q <= new_t;
            done_q  <= 1'b1;
            st_q    <= C_IDLE;
          end
        end
        default: st_q <= C_IDLE;
      endcase
    end
  end

  smst_div #(
    .NW (NW),
    .DW (DDW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  smst_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rt_start),
    .val_i   (div_quo[31:0]),
    .done_o  (rt_done),
    .root_o  (rt_root)
  );

  assign busy_o = (st_q != C_IDLE);
  assign done_o = done_q;
  assign res_o  = '{line_width: lw_q, turn: cur_t_q, mode_n: cur_n_q, mode_m: cur_m_q};

  // Norms never exceed one
  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == C_STEP) |-> (nflux_q <= NORM_ONE && nrms_q <= NORM_ONE))
    else $error("norm out of range");

  // A result is committed only into a free output slot
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(out_free_i))
    else $error("result committed while output busy");

  // A frame start taken in idle always moves the sequencer on to the mean step
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && st_q == C_IDLE) |=> (st_q == C_MEAN))
    else $error("frame start lost");

endmodule

// ===== hdl/spectrum_mode_slew_tracker_unit.sv =====
// Top level of the spectrum mode slew tracker: bin stream, configuration and result register.
//
// For each accepted bin the previous-frame memory is read in the accept cycle and
// written back with the new magnitude in the next, when the sums are updated; no
// new bin is accepted before that write. On the last bin of a frame the block
// runs an end-of-frame sequence built on one shared bit-serial divider, used up to six
// times with WW+18 steps each (WW = 16 + clog2(MAX_BINS) + clog2(MAX_BINS+1)), and a
// 16-step square root. No bins are accepted during that sequence. The result waits
// in an output register while the next frame streams in. The previous-frame store
// needs no clearing pass: a fill count makes entries not yet written read as zero,
// so reset and a change of bin count take effect at once.
module spectrum_mode_slew_tracker_unit import smst_pkg::*; #(
  parameter int MAX_BINS = MAX_BINS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] magnitude
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [15:0] mode_m, [31:16] mode_n, [47:32] turn,
                                      // [59:48] line_width, [63:60] zero
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  localparam int AW   = $clog2(MAX_BINS);
  localparam int CW   = $clog2(MAX_BINS + 1);
  localparam int SQ_W = 32 + CW;
  localparam int FX_W = 16 + CW;
  localparam int TW   = 16 + CW;
  localparam int WW   = 16 + AW + CW;
  localparam int K3   = CW + 1;
  localparam int R3   = ((1 << K3) + 2) / 3;

  typedef enum logic [1:0] {ST_IDLE, ST_UPD, ST_CALC} top_state_e;

  top_state_e          st_q;
  logic [AW-1:0]       pos_q;
  logic [15:0]         mag_q;
  logic [SQ_W-1:0]     sq_q;
  logic [FX_W-1:0]     flux_q;
  logic [2:0][WW-1:0]  wsum_q;
  logic [2:0][TW-1:0]  tot_q;
  logic [8:0]          bin_count_q;
  cfg_t                cfg_q;
  logic                out_valid_q;
  res_t                out_q;
  logic                calc_go_q;

  logic [CW-1:0]       count;
  logic [CW-1:0]       new_count;
  logic [CW+K3-1:0]    band_prod;
  logic [CW-1:0]       band;
  logic                in_acc;
  logic [15:0]         prev;
  logic [1:0]          bsel;
  logic [AW-1:0]       off;
  logic                last_bin;
  logic                count_chg;
  logic                calc_start;
  logic                calc_busy;
  logic                calc_done;
  res_t                calc_res;

  // Effective bin count, clamped to the supported range
  function automatic logic [CW-1:0] eff_count(input logic [8:0] c);
    begin
      if (c < 9'(MIN_BINS)) begin
        eff_count = CW'(MIN_BINS);
      end else if (32'(c) > 32'(MAX_BINS)) begin
        eff_count = CW'(MAX_BINS);
      end else begin
        eff_count = CW'(c);
      end
    end
  endfunction

  // Band width by reciprocal multiplication, exact over the count range
  always_comb begin
    count     = eff_count(bin_count_q);
    new_count = eff_count(cfg_data_i[8:0]);
    band_prod = count * K3'(R3);
    band      = CW'(band_prod >> K3);
    count_chg = cfg_we_i && (cfg_idx_i == REG_BIN_COUNT) && (new_count != count);
  end

  // Band selection and offset of the bin in update
  always_comb begin
    if (CW'(pos_q) < band) begin
      bsel = 2'd0;
      off  = pos_q;
    end else if (CW'(pos_q) < (band << 1)) begin
      bsel = 2'd1;
      off  = AW'(CW'(pos_q) - band);
    end else begin
      bsel = 2'd2;
      off  = AW'(CW'(pos_q) - (band << 1));
    end
    last_bin = ((CW'(pos_q) + 1'b1) == count);
  end

  assign s_axis_tready = (st_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign calc_start    = (st_q == ST_UPD) && last_bin;

  // Bin stream, frame sums, configuration and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      pos_q       <= '0;
      sq_q        <= '0;
      flux_q      <= '0;
      wsum_q      <= '0;
      tot_q       <= '0;
      out_valid_q <= 1'b0;
      calc_go_q   <= 1'b0;
      bin_count_q <= BIN_COUNT_RST;
      cfg_q       <= '{rms_decay: RMS_DECAY_RST, flux_decay: FLUX_DECAY_RST,
                       mode_step_min: MODE_STEP_MIN_RST, mode_step_max: MODE_STEP_MAX_RST,
                       turn_step_min: TURN_STEP_MIN_RST, turn_step_max: TURN_STEP_MAX_RST};
    end else begin
      // Launch the frame sequence once the last bin is in the sums
      calc_go_q <= calc_start;

      case (st_q)
        ST_IDLE: begin
          if (in_acc) begin
            mag_q <= s_axis_tdata;
            st_q  <= ST_UPD;
          end
        end
        ST_UPD: begin
          sq_q <= sq_q + SQ_W'(mag_q * mag_q);
          if (mag_q > prev) flux_q <= flux_q + FX_W'(mag_q - prev);
          wsum_q[bsel] <= wsum_q[bsel] + WW'(off * mag_q);
          tot_q[bsel]  <= tot_q[bsel] + TW'(mag_q);
          if (last_bin) begin
            st_q <= ST_CALC;
          end else begin
            pos_q <= pos_q + 1'b1;
            st_q  <= ST_IDLE;
          end
        end
        ST_CALC: begin
          if (calc_done) begin
            pos_q  <= '0;
            sq_q   <= '0;
            flux_q <= '0;
            wsum_q <= '0;
            tot_q  <= '0;
            st_q   <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase

      // Hold the result until the transaction completes
      if (calc_done) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      // Register writes; a change of the effective bin count drops the frame in progress
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_BIN_COUNT:     bin_count_q         <= cfg_data_i[8:0];
          REG_RMS_DECAY:     cfg_q.rms_decay     <= cfg_data_i;
          REG_FLUX_DECAY:    cfg_q.flux_decay    <= cfg_data_i;
          REG_MODE_STEP_MIN: cfg_q.mode_step_min <= cfg_data_i;
          REG_MODE_STEP_MAX: cfg_q.mode_step_max <= cfg_data_i;
          REG_TURN_STEP_MIN: cfg_q.turn_step_min <= cfg_data_i;
          REG_TURN_STEP_MAX: cfg_q.turn_step_max <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (count_chg) begin
        pos_q  <= '0;
        sq_q   <= '0;
        flux_q <= '0;
        wsum_q <= '0;
        tot_q  <= '0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (calc_done) out_q <= calc_res;
  end

  smst_prev_mem #(
    .DEPTH (MAX_BINS)
  ) u_prev_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (count_chg),
    .rd_en_i   (in_acc),
    .rd_addr_i (pos_q),
    .rd_data_o (prev),
    .wr_en_i   (st_q == ST_UPD),
    .wr_addr_i (pos_q),
    .wr_data_i (mag_q)
  );

  smst_frame_calc #(
    .MAX_BINS (MAX_BINS)
  ) u_frame_calc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (calc_go_q),
    .count_i    (count),
    .band_i     (band),
    .sq_i       (sq_q),
    .flux_i     (flux_q),
    .wsum_i     (wsum_q),
    .tot_i      (tot_q),
    .cfg_i      (cfg_q),
    .out_free_i (!out_valid_q),
    .busy_o     (calc_busy),
    .done_o     (calc_done),
    .res_o      (calc_res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_q.line_width, out_q.turn, out_q.mode_n, out_q.mode_m};

  // No bin is taken while the end-of-frame sequence runs
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    calc_busy |-> !s_axis_tready)
    else $error("bin accepted during frame sequence");

  // Bin position stays inside the frame
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CW'(pos_q) < count))
    else $error("bin position beyond frame");

  // A finished result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    calc_done |-> !out_valid_q)
    else $error("result overwritten");

endmodule
